// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int OCC_W       = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_POP_HEAD,
        ST_POP_RD,
        ST_POP_SH,
        ST_DONE
    } t_state;

    typedef enum logic {
        WR_KEY,
        WR_SHIFT
    } t_wr_sel;

    typedef struct packed {
        logic              load_key;
        logic              cap_head;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        t_wr_sel           wr_sel;
    } t_dp_ctl;

    typedef struct packed {
        logic              gt;
    } t_dp_stat;

    function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] count);
        logic [31:0] wide;
        wide = 32'(count);
        return wide[OCC_W-1:0];
    endfunction

endpackage

// ===== rtl/spq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels for queue requests and results.
// ----------------------------------------------------------------------------
interface spq_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] value;

    modport source (output valid, mode, value, input ready);
    modport sink   (input valid, mode, value, output ready);
endinterface

interface spq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] popped_value;
    logic        popped_valid;
    logic [4:0]  occupancy;

    modport source (output valid, status, popped_value, popped_valid, occupancy,
                    input ready);
    modport sink   (input valid, status, popped_value, popped_valid, occupancy,
                    output ready);
endinterface

// ===== rtl/spq_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_store
// Sorted value store with registered read port and the shared signed compare.
// ----------------------------------------------------------------------------
module spq_store
    import spq_pkg::*;
(
    input  logic                    i_clk,
    input  t_dp_ctl                 i_ctl,
    input  logic signed [VAL_W-1:0] i_value,
    output t_dp_stat                o_stat,
    output logic signed [VAL_W-1:0] o_head
);

    logic signed [VAL_W-1:0] r_mem [QUEUE_DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;
    logic signed [VAL_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_head;
    logic signed [VAL_W-1:0] wr_data;

    assign wr_data = (i_ctl.wr_sel == WR_SHIFT) ? r_rd_data : r_key;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[i_ctl.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_key) begin
            r_key <= i_value;
        end
        if (i_ctl.cap_head) begin
            r_head <= r_rd_data;
        end
    end

    // shared compare: stored entry strictly above the key
    assign o_stat.gt = (r_rd_data > r_key);
    assign o_head    = r_head;

endmodule

// ===== rtl/spq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer that walks the store one entry at a time for insert and pop.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_mode,
    input  logic             i_out_free,
    input  t_dp_stat         i_stat,
    output logic             o_ready,
    output t_dp_ctl          o_ctl,
    output logic             o_done,
    output t_status          o_status,
    output logic             o_popped_valid,
    output logic [CNT_W-1:0] o_count
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    t_status          r_status, n_status;
    logic             r_pvalid, n_pvalid;
    logic             accept;
    logic             is_full;
    logic [CNT_W:0]   idx_plus2;

    assign accept    = i_valid && (r_state == ST_IDLE);
    assign is_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign idx_plus2 = (CNT_W+1)'(r_idx) + (CNT_W+1)'(2);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_status = r_status;
        n_pvalid = r_pvalid;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_status = STAT_DONE;
                    n_pvalid = 1'b0;
                    if (i_mode == MODE_INSERT) begin
                        if (is_full) begin
                            n_status = STAT_FULL;
                            n_state  = ST_DONE;
                        end else begin
                            n_idx   = r_count[IDX_W-1:0];
                            n_state = (r_count == '0) ? ST_INS_PUT : ST_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                            n_state  = ST_DONE;
                        end else begin
                            n_state = ST_POP_HEAD;
                        end
                    end
                end
            end
            ST_INS_RD: begin
                n_state = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                if (i_stat.gt) begin
                    n_idx   = r_idx - IDX_W'(1);
                    n_state = (r_idx == IDX_W'(1)) ? ST_INS_PUT : ST_INS_RD;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    n_state = ST_DONE;
                end
            end
            ST_INS_PUT: begin
                n_count = r_count + CNT_W'(1);
                n_state = ST_DONE;
            end
            ST_POP_HEAD: begin
                n_pvalid = 1'b1;
                n_idx    = '0;
                if (r_count == CNT_W'(1)) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_POP_RD;
                end
            end
            ST_POP_RD: begin
                n_state = ST_POP_SH;
            end
            ST_POP_SH: begin
                n_idx = r_idx + IDX_W'(1);
                if (idx_plus2 < (CNT_W+1)'(r_count)) begin
                    n_state = ST_POP_RD;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready        = (r_state == ST_IDLE);
        o_done         = 1'b0;
        o_ctl.load_key = accept;
        o_ctl.cap_head = 1'b0;
        o_ctl.rd_addr  = '0;
        o_ctl.wr_en    = 1'b0;
        o_ctl.wr_addr  = r_idx;
        o_ctl.wr_sel   = WR_KEY;
        case (r_state)
            ST_INS_RD: begin
                o_ctl.rd_addr = r_idx - IDX_W'(1);
            end
            ST_INS_CMP: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = i_stat.gt ? WR_SHIFT : WR_KEY;
            end
            ST_INS_PUT: begin
                o_ctl.wr_en = 1'b1;
            end
            ST_POP_HEAD: begin
                o_ctl.cap_head = 1'b1;
            end
            ST_POP_RD: begin
                o_ctl.rd_addr = r_idx + IDX_W'(1);
            end
            ST_POP_SH: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = WR_SHIFT;
            end
            ST_DONE: begin
                o_done = i_out_free;
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_count  <= '0;
            r_status <= STAT_DONE;
            r_pvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_status <= n_status;
            r_pvalid <= n_pvalid;
        end
    end

    assign o_status       = r_status;
    assign o_popped_valid = r_pvalid;
    assign o_count        = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_count_moves_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_state == ST_DONE || r_state == ST_IDLE))
        else $error("entry count changed mid operation");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_status == STAT_FULL) |-> is_full)
        else $error("full status with free entries");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_status == STAT_EMPTY) |-> (r_count == '0 && !r_pvalid))
        else $error("empty status with stored entries");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle");

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded ascending priority queue: insert keeps arrival order among equal
// values, pop removes the smallest value.
//
//   channel  | dir | payload                                          | accept
//   i_req    | in  | mode, value                                      | valid & ready
//   o_rsp    | out | status, popped_value, popped_valid, occupancy    | valid & ready
//
// insert: moves each larger entry up one slot from the tail, then writes the key;
// pop: captures the head and shifts the rest down; full insert or empty pop: status only
// each moved entry costs a registered read and a write of the store
// i_req.ready is high only while the sequencer is idle; a finished result
// waits in the output register while the next request is taken
// synchronous active-low reset empties the queue; stored values are not cleared
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_in_if.sink     i_req,
    spq_out_if.source  o_rsp
);

    t_dp_ctl                 dp_ctl;
    t_dp_stat                dp_stat;
    logic signed [VAL_W-1:0] head;
    logic                    out_free;
    logic                    done;
    t_status                 status;
    logic                    pvalid;
    logic [CNT_W-1:0]        count;

    logic                    r_out_valid;
    logic [1:0]              r_status;
    logic [VAL_W-1:0]        r_popped_value;
    logic                    r_popped_valid;
    logic [OCC_W-1:0]        r_occupancy;

    assign out_free = !r_out_valid || o_rsp.ready;

    spq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_req.valid),
        .i_mode         (i_req.mode),
        .i_out_free     (out_free),
        .i_stat         (dp_stat),
        .o_ready        (i_req.ready),
        .o_ctl          (dp_ctl),
        .o_done         (done),
        .o_status       (status),
        .o_popped_valid (pvalid),
        .o_count        (count)
    );

    spq_store u_store (
        .i_clk   (i_clk),
        .i_ctl   (dp_ctl),
        .i_value (i_req.value),
        .o_stat  (dp_stat),
        .o_head  (head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_status       <= status;
            r_popped_value <= pvalid ? head : '0;
            r_popped_valid <= pvalid;
            r_occupancy    <= to_occ(count);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.popped_value = r_popped_value;
    assign o_rsp.popped_valid = r_popped_valid;
    assign o_rsp.occupancy    = r_occupancy;

endmodule

// ===== tb/sorted_priority_queue_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_test
// Self-checking bench for the sorted priority queue. A short table of
// directed requests covers empty pops, extreme values, duplicates and the
// full store. It is followed by random insert/pop traffic whose mix is redrawn
// between pop-heavy, balanced and insert-heavy, so the queue keeps going empty
// and full. Every result is compared field by field with its typed row or the
// behavioral store model. Both channels idle at random except near the end.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_test
    import spq_pkg::*;
();

    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  popped_value;
        logic              popped_valid;
        logic [OCC_W-1:0]  occupancy;
    } t_queue_rsp;

    typedef struct packed {
        logic              mode;
        logic [VAL_W-1:0]  value;
        logic              typed;
        t_queue_rsp        rsp;
    } t_directed_step;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 1500;
    localparam int QUIET_START  = 1300;
    localparam int DRAIN_CYCLES = 4 * QUEUE_DEPTH + 20;

    logic i_clk;
    logic i_rst_n;

    spq_in_if  req_if ();
    spq_out_if rsp_if ();

    sorted_priority_queue_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // model of the sorted store
    logic signed [VAL_W-1:0] model_store [QUEUE_DEPTH];
    int                      model_count;

    t_queue_rsp pending_results [$];
    int         error_count;
    bit         quiet_tail;

    // expected results: typed rows carry their own, the rest come from the model
    t_directed_step directed_steps [N_DIRECTED] = '{
        '{MODE_POP,    32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0000_0000, 1'b0, 5'd0}},
        '{MODE_INSERT, 32'h7fff_ffff, 1'b1, '{STAT_DONE,  32'h0000_0000, 1'b0, 5'd1}},
        '{MODE_INSERT, 32'h8000_0000, 1'b1, '{STAT_DONE,  32'h0000_0000, 1'b0, 5'd2}},
        '{MODE_POP,    32'hffff_ffff, 1'b1, '{STAT_DONE,  32'h8000_0000, 1'b1, 5'd1}},
        '{MODE_POP,    32'h0000_0000, 1'b1, '{STAT_DONE,  32'h7fff_ffff, 1'b1, 5'd0}},
        '{MODE_POP,    32'h1234_5678, 1'b1, '{STAT_EMPTY, 32'h0000_0000, 1'b0, 5'd0}},
        '{MODE_INSERT, 32'h0000_0005, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_0005, 1'b0, '0},
        '{MODE_INSERT, 32'hffff_ffff, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_0000, 1'b0, '0},
        '{MODE_INSERT, 32'h7fff_ffff, 1'b0, '0},
        '{MODE_INSERT, 32'h8000_0000, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_0005, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_0001, 1'b0, '0},
        '{MODE_INSERT, 32'hffff_fffe, 1'b0, '0},
        '{MODE_INSERT, 32'h7fff_fffe, 1'b0, '0},
        '{MODE_INSERT, 32'h8000_0001, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_0003, 1'b0, '0},
        '{MODE_INSERT, 32'hffff_ffff, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_0002, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_0005, 1'b0, '0},
        '{MODE_INSERT, 32'haaaa_aaaa, 1'b0, '0},
        '{MODE_INSERT, 32'h5555_5555, 1'b1, '{STAT_FULL,  32'h0000_0000, 1'b0, 5'd16}},
        '{MODE_POP,    32'h0000_0000, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_0004, 1'b0, '0}
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_queue_rsp apply_queue_op(input logic mode,
                                                  input logic [VAL_W-1:0] value);
        t_queue_rsp rsp;
        int         slot;
        rsp = '{STAT_DONE, '0, 1'b0, '0};
        if (mode == MODE_INSERT) begin
            if (model_count >= QUEUE_DEPTH) begin
                rsp.status = STAT_FULL;
            end else begin
                slot = model_count;
                for (int i = 0; i < model_count; i++) begin
                    if (model_store[i] > $signed(value)) begin
                        slot = i;
                        break;
                    end
                end
                for (int i = model_count; i > slot; i--) begin
                    model_store[i] = model_store[i-1];
                end
                model_store[slot] = $signed(value);
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                rsp.status = STAT_EMPTY;
            end else begin
                rsp.popped_value = model_store[0];
                rsp.popped_valid = 1'b1;
                for (int i = 0; i + 1 < model_count; i++) begin
                    model_store[i] = model_store[i+1];
                end
                model_count--;
            end
        end
        rsp.occupancy = model_count[OCC_W-1:0];
        return rsp;
    endfunction

    task automatic issue_request(input logic mode, input logic [VAL_W-1:0] value,
                                 input logic typed, input t_queue_rsp typed_rsp);
        t_queue_rsp predicted;
        req_if.valid <= 1'b1;
        req_if.mode  <= mode;
        req_if.value <= value;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = apply_queue_op(mode, value);
        pending_results.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic hold_request_idle(input int gap_pct);
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // result channel back-pressure
    initial begin
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 1) == 1) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_queue_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: status %0d occupancy %0d",
                       rsp_if.status, rsp_if.occupancy);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                    error_count++;
                end
                if (rsp_if.popped_value !== want.popped_value) begin
                    $error("popped_value: expected %0d, actual %0d",
                           $signed(want.popped_value), $signed(rsp_if.popped_value));
                    error_count++;
                end
                if (rsp_if.popped_valid !== want.popped_valid) begin
                    $error("popped_valid: expected %0d, actual %0d",
                           want.popped_valid, rsp_if.popped_valid);
                    error_count++;
                end
                if (rsp_if.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, actual %0d",
                           want.occupancy, rsp_if.occupancy);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int               insert_pct;
        int               gap_pct;
        logic             mode;
        logic [VAL_W-1:0] value;
        error_count  = 0;
        quiet_tail   = 1'b0;
        model_count  = 0;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.mode  <= MODE_INSERT;
        req_if.value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[k]) begin
            hold_request_idle(30);
            issue_request(directed_steps[k].mode, directed_steps[k].value,
                          directed_steps[k].typed, directed_steps[k].rsp);
        end

        insert_pct = 50;
        gap_pct    = 30;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 20;
                    1:       insert_pct = 50;
                    default: insert_pct = 80;
                endcase
                gap_pct = $urandom_range(0, 2) * 25;
            end
            quiet_tail = (n >= QUIET_START);
            mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_POP;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: value = 32'($urandom_range(0, 16)) - 32'd8;
                4: begin
                    case ($urandom_range(0, 3))
                        0:       value = 32'h8000_0000;
                        1:       value = 32'h7fff_ffff;
                        2:       value = 32'hffff_ffff;
                        default: value = 32'h0000_0000;
                    endcase
                end
                default: value = $urandom;
            endcase
            hold_request_idle(gap_pct);
            issue_request(mode, value, 1'b0, '0);
        end
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
